### hdl/aldc_pkg.sv
// Package with the shared types, constants and preset tables of the dimming controller.
`timescale 1ns / 1ps

package aldc_pkg;

    localparam int CNT_W      = 16;
    localparam int TIMER_W    = 32;
    localparam int LEVEL_W    = 7;
    localparam int BAND_W     = 7;
    localparam int FADE_W     = 10;
    localparam int PDIFF_W    = 10;
    localparam int DIV_DVD_W  = 32;
    localparam int DIV_DVR_W  = 10;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]   COUNT_OVERFLOW = 16'hFFFF;
    localparam logic [CNT_W-1:0]   TIMER_SAT      = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 7'd100;

    localparam logic [2:0] REG_ENABLED     = 3'd0;
    localparam logic [2:0] REG_PRESET      = 3'd1;
    localparam logic [2:0] REG_STABLE_BAND = 3'd2;
    localparam logic [2:0] REG_SETTLE      = 3'd3;
    localparam logic [2:0] REG_FADE        = 3'd4;
    localparam logic [2:0] REG_SAMPLE      = 3'd5;

    localparam logic [1:0] PRESET_OFF    = 2'd0;
    localparam logic [1:0] PRESET_LOW    = 2'd1;
    localparam logic [1:0] PRESET_MEDIUM = 2'd2;
    localparam logic [1:0] PRESET_HIGH   = 2'd3;

    typedef struct packed {
        logic        enabled;
        logic [1:0]  preset;
        logic [6:0]  stable_band;
        logic [15:0] settle_delay_ms;
        logic [9:0]  fade_interval_ms;
        logic [15:0] sample_period_ms;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIVQ,
        ST_BAND,
        ST_FADE,
        ST_DIVR,
        ST_DONE
    } state_t;

    function automatic logic [9:0] preset_thr(input logic [1:0] p);
        logic [9:0] r;
        unique case (p)
            PRESET_LOW:    r = 10'd150;
            PRESET_MEDIUM: r = 10'd300;
            PRESET_HIGH:   r = 10'd600;
            default:       r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] preset_min(input logic [1:0] p);
        logic [9:0] r;
        unique case (p)
            PRESET_LOW:    r = 10'd15;
            PRESET_MEDIUM: r = 10'd15;
            PRESET_HIGH:   r = 10'd30;
            default:       r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] preset_max(input logic [1:0] p);
        logic [6:0] r;
        unique case (p)
            PRESET_LOW:    r = 7'd60;
            PRESET_MEDIUM: r = 7'd80;
            PRESET_HIGH:   r = 7'd95;
            default:       r = 7'd0;
        endcase
        return r;
    endfunction

    // Span from the minimum to the threshold, the divisor of the linear map.
    function automatic logic [9:0] preset_span(input logic [1:0] p);
        logic [9:0] r;
        unique case (p)
            PRESET_LOW:    r = 10'd135;
            PRESET_MEDIUM: r = 10'd285;
            PRESET_HIGH:   r = 10'd570;
            default:       r = 10'd1;
        endcase
        return r;
    endfunction

endpackage

### hdl/aldc_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module aldc_div #(
    parameter int DVD_W = aldc_pkg::DIV_DVD_W,
    parameter int DVR_W = aldc_pkg::DIV_DVR_W,
    parameter int NB_W  = $clog2(DVD_W + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVD_W-1:0]     dividend,
    input  logic [DVR_W-1:0]     divisor,
    input  logic [NB_W-1:0]      nbits,
    output logic [DVD_W-1:0]     quotient,
    output logic [DVR_W-1:0]     remainder,
    output aldc_pkg::div_stat_t  status
);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVR_W-1:0] rem_reg, rem_next;
    logic [DVR_W-1:0] dvr_reg, dvr_next;
    logic [NB_W-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVR_W:0]   partial;
    logic             fits;

    assign partial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits    = partial >= {1'b0, dvr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvr_next  = dvr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            dvr_next  = divisor;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            rem_next = fits ? DVR_W'(partial - {1'b0, dvr_reg}) : partial[DVR_W-1:0];
            cnt_next = cnt_reg - NB_W'(1);
            if (cnt_reg <= NB_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
    end

    assign quotient    = dvd_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### hdl/aldc_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module aldc_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aldc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [aldc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [aldc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output aldc_pkg::cfg_t                    cfg,
    output logic                              reenable
);

    aldc_pkg::cfg_t cfg_reg, cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        reenable = 1'b0;
        if (wr_en) begin
            unique case (idx)
                aldc_pkg::REG_ENABLED: begin
                    cfg_next.enabled = pwdata[0];
                    reenable = !cfg_reg.enabled && pwdata[0];
                end
                aldc_pkg::REG_PRESET:      cfg_next.preset = pwdata[1:0];
                aldc_pkg::REG_STABLE_BAND: cfg_next.stable_band = pwdata[6:0];
                aldc_pkg::REG_SETTLE:      cfg_next.settle_delay_ms = pwdata[15:0];
                aldc_pkg::REG_FADE:        cfg_next.fade_interval_ms = pwdata[9:0];
                aldc_pkg::REG_SAMPLE:      cfg_next.sample_period_ms = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            aldc_pkg::REG_ENABLED:     prdata = 32'(cfg_reg.enabled);
            aldc_pkg::REG_PRESET:      prdata = 32'(cfg_reg.preset);
            aldc_pkg::REG_STABLE_BAND: prdata = 32'(cfg_reg.stable_band);
            aldc_pkg::REG_SETTLE:      prdata = 32'(cfg_reg.settle_delay_ms);
            aldc_pkg::REG_FADE:        prdata = 32'(cfg_reg.fade_interval_ms);
            aldc_pkg::REG_SAMPLE:      prdata = 32'(cfg_reg.sample_period_ms);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled          <= 1'b1;
            cfg_reg.preset           <= aldc_pkg::PRESET_OFF;
            cfg_reg.stable_band      <= 7'd5;
            cfg_reg.settle_delay_ms  <= 16'd2000;
            cfg_reg.fade_interval_ms <= 10'd10;
            cfg_reg.sample_period_ms <= 16'd500;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg    = cfg_reg;
    assign pready = 1'b1;

endmodule

### hdl/ambient_light_dimming_controller_top.sv
// Top level of the ambient light dimming controller with its tick sequencer.
`timescale 1ns / 1ps

// Each input beat is one millisecond tick with the two sensor channel counts, and each tick
// yields exactly one output beat with the current and target dimming and a change flag.
// The block handles one tick at a time and is not ready while it works. A disabled tick goes
// straight to the output step. An enabled tick evaluates the level once the sample period is
// reached, ending at zero or running the linear map through a division, and then checks the
// band; every enabled tick then runs the fade check, which divides the time since the last
// target change by the fade interval once the settle delay has passed. The shared
// one-bit-per-cycle divider runs 16 steps for the linear map and 32 steps for the fade
// interval check. The last step of a tick also waits while the previous beat still sits
// unaccepted in the output register. Configuration is written through the APB-style port.

module ambient_light_dimming_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // visible_ir_count[15:0], infrared_count[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // current_dimming[6:0], target_dimming[13:7],
                                   // dimming_changed[14], zero[15]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DVD_W = aldc_pkg::DIV_DVD_W;
    localparam int DVR_W = aldc_pkg::DIV_DVR_W;
    localparam int NB_W  = $clog2(DVD_W + 1);

    aldc_pkg::cfg_t      cfg;
    aldc_pkg::div_stat_t div_stat;
    logic                reenable;

    aldc_pkg::state_t state_reg, state_next;
    logic [15:0] sample_timer_reg, sample_timer_next;
    logic [31:0] since_reg, since_next;
    logic [6:0]  target_reg, target_next;
    logic [6:0]  current_reg, current_next;
    logic [15:0] vis_reg, vis_next;
    logic [15:0] ir_reg, ir_next;
    logic [9:0]  pdiff_reg, pdiff_next;
    logic [6:0]  dim_reg, dim_next;
    logic        changed_reg, changed_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVR_W-1:0] div_divisor;
    logic [NB_W-1:0]  div_nbits;
    logic [DVD_W-1:0] div_quot;
    logic [DVR_W-1:0] div_rem;

    logic [15:0] perceived;
    logic [15:0] p_floor;
    logic [9:0]  thr, pmin, span;
    logic [6:0]  pmax;
    logic [16:0] product;
    logic [6:0]  band_lo;
    logic [7:0]  band_hi_raw;
    logic [7:0]  band_hi;
    logic [9:0]  interval;

    aldc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .reenable (reenable)
    );

    aldc_div #(
        .DVD_W (DVD_W),
        .DVR_W (DVR_W),
        .NB_W  (NB_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .nbits     (div_nbits),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_stat)
    );

    assign thr  = aldc_pkg::preset_thr(cfg.preset);
    assign pmin = aldc_pkg::preset_min(cfg.preset);
    assign pmax = aldc_pkg::preset_max(cfg.preset);
    assign span = aldc_pkg::preset_span(cfg.preset);

    assign perceived = (vis_reg > ir_reg) ? vis_reg - ir_reg : 16'd0;
    assign p_floor   = (perceived < 16'(pmin)) ? 16'(pmin) : perceived;
    assign product   = 17'(pdiff_reg) * 17'(pmax);

    assign band_lo     = (dim_reg < cfg.stable_band) ? 7'd0 : dim_reg - cfg.stable_band;
    assign band_hi_raw = 8'(dim_reg) + 8'(cfg.stable_band);
    assign band_hi     = (band_hi_raw > 8'(aldc_pkg::LEVEL_MAX)) ?
                         8'(aldc_pkg::LEVEL_MAX) : band_hi_raw;
    assign interval    = (cfg.fade_interval_ms == 10'd0) ? 10'd1 : cfg.fade_interval_ms;

    always_comb begin
        state_next        = state_reg;
        sample_timer_next = sample_timer_reg;
        since_next        = since_reg;
        target_next       = target_reg;
        current_next      = current_reg;
        vis_next          = vis_reg;
        ir_next           = ir_reg;
        pdiff_next        = pdiff_reg;
        dim_next          = dim_reg;
        changed_next      = changed_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        div_start         = 1'b0;
        div_dividend      = '0;
        div_divisor       = '0;
        div_nbits         = '0;
        s_tready          = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            aldc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    changed_next = 1'b0;
                    if (cfg.enabled) begin
                        vis_next = s_tdata[15:0];
                        ir_next  = s_tdata[31:16];
                        if (sample_timer_reg < aldc_pkg::TIMER_SAT) begin
                            sample_timer_next = sample_timer_reg + 16'd1;
                        end
                        since_next = since_reg + 32'd1;
                        state_next = aldc_pkg::ST_EVAL;
                    end else begin
                        state_next = aldc_pkg::ST_DONE;
                    end
                end
            end
            aldc_pkg::ST_EVAL: begin
                if (sample_timer_reg >= cfg.sample_period_ms) begin
                    if (vis_reg == aldc_pkg::COUNT_OVERFLOW ||
                        ir_reg == aldc_pkg::COUNT_OVERFLOW ||
                        cfg.preset == aldc_pkg::PRESET_OFF ||
                        p_floor >= 16'(thr)) begin
                        dim_next   = 7'd0;
                        state_next = aldc_pkg::ST_BAND;
                    end else begin
                        pdiff_next = 10'(p_floor - 16'(pmin));
                        state_next = aldc_pkg::ST_MUL;
                    end
                end else begin
                    state_next = aldc_pkg::ST_FADE;
                end
            end
            aldc_pkg::ST_MUL: begin
                div_start    = 1'b1;
                div_dividend = DVD_W'({product[15:0], 16'd0});
                div_divisor  = DVR_W'(span);
                div_nbits    = NB_W'(16);
                state_next   = aldc_pkg::ST_DIVQ;
            end
            aldc_pkg::ST_DIVQ: begin
                if (div_stat.done) begin
                    dim_next   = pmax - div_quot[6:0];
                    state_next = aldc_pkg::ST_BAND;
                end
            end
            aldc_pkg::ST_BAND: begin
                sample_timer_next = 16'd0;
                if (target_reg < band_lo || 8'(target_reg) > band_hi) begin
                    target_next = dim_reg;
                    since_next  = 32'd0;
                end
                state_next = aldc_pkg::ST_FADE;
            end
            aldc_pkg::ST_FADE: begin
                if (since_reg > 32'(cfg.settle_delay_ms)) begin
                    div_start    = 1'b1;
                    div_dividend = DVD_W'(since_reg);
                    div_divisor  = DVR_W'(interval);
                    div_nbits    = NB_W'(DVD_W);
                    state_next   = aldc_pkg::ST_DIVR;
                end else begin
                    state_next = aldc_pkg::ST_DONE;
                end
            end
            aldc_pkg::ST_DIVR: begin
                if (div_stat.done) begin
                    if (div_rem == '0) begin
                        if (target_reg > current_reg) begin
                            current_next = current_reg + 7'd1;
                            changed_next = 1'b1;
                        end else if (target_reg < current_reg) begin
                            current_next = current_reg - 7'd1;
                            changed_next = 1'b1;
                        end
                    end
                    state_next = aldc_pkg::ST_DONE;
                end
            end
            aldc_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, changed_reg, target_reg, current_reg};
                    state_next    = aldc_pkg::ST_IDLE;
                end
            end
            default: state_next = aldc_pkg::ST_IDLE;
        endcase

        if (reenable) begin
            sample_timer_next = 16'd0;
            since_next        = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= aldc_pkg::ST_IDLE;
            sample_timer_reg <= '0;
            since_reg        <= '0;
            target_reg       <= '0;
            current_reg      <= '0;
            changed_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            sample_timer_reg <= sample_timer_next;
            since_reg        <= since_next;
            target_reg       <= target_next;
            current_reg      <= current_next;
            changed_reg      <= changed_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        vis_reg     <= vis_next;
        ir_reg      <= ir_next;
        pdiff_reg   <= pdiff_next;
        dim_reg     <= dim_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        current_reg <= aldc_pkg::LEVEL_MAX && target_reg <= aldc_pkg::LEVEL_MAX)
        else $error("Dimming level left the percent range.");

    a_step_size: assert property (@(posedge aclk) disable iff (!aresetn)
        current_reg != $past(current_reg) |->
        (current_reg == $past(current_reg) + 7'd1 || current_reg == $past(current_reg) - 7'd1))
        else $error("Current dimming moved by more than one percent.");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == aldc_pkg::ST_DIVQ || state_reg == aldc_pkg::ST_DIVR) |->
        (div_stat.busy || div_stat.done))
        else $error("Sequencer waits on an idle divider.");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("Divider restarted while busy.");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("New beat accepted while the divider is working.");

endmodule

### tb/testbench.sv
// Self-checking testbench for the ambient light dimming controller top level.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 10;
    localparam int PHASE_TICKS  = 55;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [6:0] current;
        logic [6:0] target;
        logic       changed;
    } dim_beat_t;

    class dimming_tracker;
        bit        en;
        bit [1:0]  preset;
        bit [6:0]  band;
        bit [15:0] settle_ms;
        bit [9:0]  fade_ms;
        bit [15:0] period_ms;
        bit [15:0] sample_age;
        bit [31:0] settle_age;
        bit [6:0]  target_lvl;
        bit [6:0]  current_lvl;
        dim_beat_t expected_beats[$];
        int        errors;
        int        reported;

        function new();
            en = 1'b1;
            preset = aldc_pkg::PRESET_OFF;
            band = 7'd5;
            settle_ms = 16'd2000;
            fade_ms = 10'd10;
            period_ms = 16'd500;
            sample_age = '0;
            settle_age = '0;
            target_lvl = '0;
            current_lvl = '0;
            errors = 0;
            reported = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                aldc_pkg::REG_ENABLED: begin
                    if (!en && val[0]) begin
                        sample_age = '0;
                        settle_age = '0;
                    end
                    en = val[0];
                end
                aldc_pkg::REG_PRESET:      preset = val[1:0];
                aldc_pkg::REG_STABLE_BAND: band = val[6:0];
                aldc_pkg::REG_SETTLE:      settle_ms = val[15:0];
                aldc_pkg::REG_FADE:        fade_ms = val[9:0];
                aldc_pkg::REG_SAMPLE:      period_ms = val[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned dimming_for_counts(bit [15:0] vis, bit [15:0] ir);
            int unsigned thr, floor_lvl, top, p;
            if (vis == aldc_pkg::COUNT_OVERFLOW || ir == aldc_pkg::COUNT_OVERFLOW) return 0;
            case (preset)
                aldc_pkg::PRESET_LOW: begin
                    thr = 150; floor_lvl = 15; top = 60;
                end
                aldc_pkg::PRESET_MEDIUM: begin
                    thr = 300; floor_lvl = 15; top = 80;
                end
                aldc_pkg::PRESET_HIGH: begin
                    thr = 600; floor_lvl = 30; top = 95;
                end
                default: return 0;
            endcase
            p = (vis > ir) ? vis - ir : 0;
            if (p < floor_lvl) p = floor_lvl;
            if (p >= thr) return 0;
            return top - ((p - floor_lvl) * top) / (thr - floor_lvl);
        endfunction

        function void accept_tick(bit [15:0] vis, bit [15:0] ir);
            int unsigned d, lo, hi, step;
            dim_beat_t b;
            b.changed = 1'b0;
            if (en) begin
                if (sample_age != 16'hFFFF) sample_age++;
                settle_age++;
                if (sample_age >= period_ms) begin
                    d = dimming_for_counts(vis, ir);
                    lo = (d < band) ? 0 : d - band;
                    hi = d + band;
                    if (hi > 100) hi = 100;
                    sample_age = '0;
                    if (target_lvl < lo || target_lvl > hi) begin
                        target_lvl = d[6:0];
                        settle_age = '0;
                    end
                end
                step = (fade_ms == 0) ? 1 : fade_ms;
                if (settle_age > settle_ms && settle_age % step == 0) begin
                    if (target_lvl > current_lvl) begin
                        current_lvl++;
                        b.changed = 1'b1;
                    end else if (target_lvl < current_lvl) begin
                        current_lvl--;
                        b.changed = 1'b1;
                    end
                end
            end
            b.current = current_lvl;
            b.target = target_lvl;
            expected_beats.push_back(b);
        endfunction

        function void note_error(string what, int exp_val, int act_val);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("Mismatch on %s at %0t: expected %0d, got %0d",
                         what, $time, exp_val, act_val);
            end
        endfunction

        function void check_beat(logic [15:0] data);
            dim_beat_t e;
            if (expected_beats.size() == 0) begin
                note_error("unexpected beat, pending count", 0, 1);
                return;
            end
            e = expected_beats.pop_front();
            if (data[6:0] !== e.current) note_error("current_dimming", e.current, data[6:0]);
            if (data[13:7] !== e.target) note_error("target_dimming", e.target, data[13:7]);
            if (data[14] !== e.changed) note_error("dimming_changed", e.changed, data[14]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // visible_ir_count[15:0], infrared_count[31:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // current_dimming[6:0], target_dimming[13:7],
                            // dimming_changed[14], zero[15]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dimming_tracker tracker = new();
    int          send_gap_pct;
    int          sink_stall_pct;
    int          cycle_count;
    int          scene_diff;

    ambient_light_dimming_controller_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_beat(m_tdata);
    end

    always @(negedge aclk) begin
        m_tready = (int'($urandom_range(0, 99)) >= sink_stall_pct);
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.write_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(input int en, input int pre, input int bnd, input int settle,
                              input int fade, input int period);
        reg_write(aldc_pkg::REG_ENABLED, en);
        reg_write(aldc_pkg::REG_PRESET, pre);
        reg_write(aldc_pkg::REG_STABLE_BAND, bnd);
        reg_write(aldc_pkg::REG_SETTLE, settle);
        reg_write(aldc_pkg::REG_FADE, fade);
        reg_write(aldc_pkg::REG_SAMPLE, period);
    endtask

    task automatic send_tick(input logic [15:0] vis, input logic [15:0] ir);
        if (int'($urandom_range(0, 99)) < send_gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {ir, vis};
        do @(posedge aclk); while (!s_tready);
        tracker.accept_tick(vis, ir);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (tracker.expected_beats.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Light follows a slowly changing scene with jitter, plus overflow and noise beats.
    task automatic scene_tick();
        int r, ir, d, vis;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_tick(aldc_pkg::COUNT_OVERFLOW, 16'($urandom));
        end else if (r < 6) begin
            send_tick(16'($urandom), aldc_pkg::COUNT_OVERFLOW);
        end else if (r < 12) begin
            send_tick(16'($urandom), 16'($urandom));
        end else begin
            if ($urandom_range(0, 19) == 0) scene_diff = int'($urandom_range(0, 700)) - 50;
            ir = $urandom_range(0, 3000);
            d = scene_diff + int'($urandom_range(0, 6)) - 3;
            if (d < 0) vis = (ir > -d) ? ir + d : 0;
            else vis = ir + d;
            send_tick(16'(vis), 16'(ir));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_gap_pct = 0;
        sink_stall_pct = 0;
        cycle_count = 0;
        scene_diff = 100;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        // Zero sample period and zero fade interval: evaluate and step on every tick.
        set_config(1, int'(aldc_pkg::PRESET_LOW), 0, 0, 0, 0);
        send_tick(16'd0, 16'd0);
        send_tick(16'hFFFF, 16'd0);
        send_tick(16'd0, 16'hFFFF);
        send_tick(16'd164, 16'd14);
        send_tick(16'd149, 16'd0);
        send_tick(16'd100, 16'd200);
        send_tick(16'd15, 16'd0);
        drain();
        reg_write(aldc_pkg::REG_PRESET, 32'(aldc_pkg::PRESET_MEDIUM));
        send_tick(16'd299, 16'd0);
        send_tick(16'd300, 16'd0);
        send_tick(16'd1000, 16'd990);
        drain();
        // A band wider than the level range keeps the target fixed.
        reg_write(aldc_pkg::REG_PRESET, 32'(aldc_pkg::PRESET_HIGH));
        reg_write(aldc_pkg::REG_STABLE_BAND, 127);
        send_tick(16'd629, 16'd29);
        send_tick(16'd599, 16'd0);
        send_tick(16'd0, 16'd0);
        drain();
        // While disabled nothing moves; enabling again restarts both timers.
        reg_write(aldc_pkg::REG_ENABLED, 0);
        send_tick(16'd40, 16'd0);
        send_tick(16'd40, 16'd0);
        drain();
        set_config(1, int'(aldc_pkg::PRESET_HIGH), 5, 2, 2, 3);
        repeat (4) send_tick(16'd40, 16'd0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    send_gap_pct = 0; sink_stall_pct = 0;
                end
                1: begin
                    send_gap_pct = 56; sink_stall_pct = 0;
                end
                2: begin
                    send_gap_pct = 0; sink_stall_pct = 56;
                end
                default: begin
                    send_gap_pct = 36; sink_stall_pct = 36;
                end
            endcase
            if (ph == 0)
                set_config(1, $urandom_range(1, 3), 0, 0, 0, 0);
            else if (ph == PHASES - 1)
                set_config(1, $urandom_range(1, 3), 100, 65535, 1023, 65535);
            else
                set_config(1, ($urandom_range(0, 9) == 0) ?
                           int'(aldc_pkg::PRESET_OFF) : int'($urandom_range(1, 3)),
                           ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 15),
                           $urandom_range(0, 30), $urandom_range(1, 4),
                           $urandom_range(1, 6));
            for (int i = 0; i < PHASE_TICKS; i++) begin
                if (ph == 3 && i == 30) drain();
                if (ph == 5 && i == 20) begin
                    drain();
                    reg_write(aldc_pkg::REG_ENABLED, 0);
                    repeat (8) scene_tick();
                    drain();
                    reg_write(aldc_pkg::REG_ENABLED, 1);
                end
                scene_tick();
            end
            drain();
        end

        tracker.errors += tracker.expected_beats.size();
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/aldc_pkg.sv
hdl/aldc_div.sv
hdl/aldc_cfg.sv
hdl/ambient_light_dimming_controller_top.sv
tb/testbench.sv
